### hw/rtl/mlws_pkg.sv
// Shared types and fixed constants for the shortest-window-sum block.
// No dependencies; imported by the core and the response register.
`timescale 1ns / 1ps

package mlws_pkg;

   localparam int VALUE_FIELD_W = 16;
   localparam int BEST_LEN_W    = 11;
   localparam int TARGET_W      = 32;

   localparam logic [TARGET_W-1:0] TARGET_RESET = 32'd1;

   typedef struct packed {
      logic [VALUE_FIELD_W-1:0] value;
      logic                     is_last;
   } req_type;

   typedef struct packed {
      logic [BEST_LEN_W-1:0] best_length;
      logic                  found;
      logic                  is_final;
      logic                  overflow;
   } rsp_type;

endpackage

### hw/rtl/mlws_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mlws_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/mlws_rsp_reg.sv
// Output holding register for the response channel.
// Depends on mlws_pkg for the response type.
`timescale 1ns / 1ps

module mlws_rsp_reg
   import mlws_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // slot can take a new beat if empty or draining this cycle
   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("response loaded while slot is occupied");

endmodule

### hw/rtl/min_length_window_sum_at_least_core.sv
// Shortest-window-sum tracker: top level with sequencer and running state.
// Depends on mlws_pkg, mlws_ram and mlws_rsp_reg.
`timescale 1ns / 1ps

// Each input beat appends a value to a window held in an internal RAM and
// reports the shortest window so far whose sum reaches csr target (0 = none).
// A stored item is taken in ST_IDLE and stays in ST_CHECK while old elements
// are dropped from the window; the drop loop is paced by the single RAM read
// port, one element per cycle. An item past DEPTH is not stored and finishes
// in ST_IDLE. Each element is dropped at most once. A finished result sits
// in an output register, so the next item is taken while it waits; only when
// that register is still full at the end of an item does the block hold.
// Items past DEPTH come back with overflow set. The window state clears after
// a last-flagged item. Write the target only while the block is idle.
module min_length_window_sum_at_least_core
   import mlws_pkg::*;
#(
   parameter int DEPTH       = 1024,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_wr_en,
   input  logic [TARGET_W-1:0] csr_wr_data
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int SW    = VALUE_WIDTH + CW;
   localparam int CMPW  = (SW > TARGET_W) ? SW : TARGET_W;
   localparam int VEXTW = (VALUE_WIDTH > VALUE_FIELD_W) ? VALUE_WIDTH : VALUE_FIELD_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic [TARGET_W-1:0] target_ff;
   logic [SW-1:0]       total_ff, total_in;
   logic [AW-1:0]       left_ff, left_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       best_ff, best_in;
   logic                last_ff, last_in;
   logic                ovf_ff, ovf_in;

   logic [VEXTW-1:0]       value_ext;
   logic [VALUE_WIDTH-1:0] value;
   logic                   accept;
   logic                   full;
   logic                   wr_en;
   logic [AW-1:0]          rd_addr;
   logic [VALUE_WIDTH-1:0] rd_data;
   logic [SW-1:0]          diff;
   logic                   more_left;
   logic                   drop;
   logic                   qualifies;
   logic [CW-1:0]          win_len;
   logic [CW-1:0]          best_next;
   logic                   rsp_free;
   logic                   rsp_load;
   rsp_type                rsp_next;
   logic                   finish;
   logic [CW-1:0]          fin_best;

   assign value_ext = VEXTW'(req_data.value);
   assign value     = value_ext[VALUE_WIDTH-1:0];

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CW'(DEPTH));
   assign wr_en     = accept && !full;

   // drop-loop datapath: rd_data is the oldest kept element
   assign diff      = total_ff - SW'(rd_data);
   assign more_left = (CW'(left_ff) + CW'(1)) < count_ff;
   assign drop      = (state_ff == ST_CHECK) && more_left &&
                      (CMPW'(diff) >= CMPW'(target_ff));
   assign qualifies = CMPW'(total_ff) >= CMPW'(target_ff);
   assign win_len   = count_ff - CW'(left_ff);
   assign best_next = (qualifies && (best_ff == '0 || win_len < best_ff)) ?
                      win_len : best_ff;
   assign rd_addr   = drop ? (left_ff + AW'(1)) : left_ff;

   mlws_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      left_in  = left_ff;
      count_in = count_ff;
      best_in  = best_ff;
      last_in  = last_ff;
      ovf_in   = ovf_ff;
      finish   = 1'b0;
      fin_best = best_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_data.is_last;
               ovf_in  = full;
               if (full) begin
                  finish = 1'b1;
               end else begin
                  total_in = total_ff + SW'(value);
                  count_in = count_ff + CW'(1);
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (drop) begin
               total_in = diff;
               left_in  = left_ff + AW'(1);
            end else begin
               best_in  = best_next;
               fin_best = best_next;
               finish   = 1'b1;
            end
         end
         ST_EMIT: begin
            finish = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_load = finish && rsp_free;
      if (finish) begin
         if (rsp_free) begin
            state_in = ST_IDLE;
            if (state_ff == ST_IDLE ? req_data.is_last : last_ff) begin
               total_in = '0;
               left_in  = '0;
               count_in = '0;
               best_in  = '0;
            end
         end else begin
            state_in = ST_EMIT;
         end
      end
   end

   always_comb begin
      rsp_next.best_length = BEST_LEN_W'(fin_best);
      rsp_next.found       = (fin_best != '0);
      rsp_next.is_final    = (state_ff == ST_IDLE) ? req_data.is_last : last_ff;
      rsp_next.overflow    = (state_ff == ST_IDLE) ? full : ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         target_ff <= TARGET_RESET;
         total_ff  <= '0;
         left_ff   <= '0;
         count_ff  <= '0;
         best_ff   <= '0;
         last_ff   <= 1'b0;
         ovf_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         left_ff  <= left_in;
         count_ff <= count_in;
         best_ff  <= best_in;
         last_ff  <= last_in;
         ovf_ff   <= ovf_in;
         if (csr_wr_en) begin
            target_ff <= csr_wr_data;
         end
      end
   end

   mlws_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .load_data (rsp_next),
      .free      (rsp_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> CW'(left_ff) < count_ff)
      else $error("left index ran past the newest element");

   assert property (@(posedge clock) disable iff (reset)
      best_ff <= count_ff)
      else $error("best length longer than the sequence");

   assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> total_ff == '0 && left_ff == '0)
      else $error("window state not clear on empty sequence");

   assert property (@(posedge clock) disable iff (reset)
      wr_en |=> state_ff == ST_CHECK && count_ff == $past(count_ff) + CW'(1))
      else $error("stored beat did not enter the drop loop");

endmodule

### test/tb.sv
// Self-checking bench for min_length_window_sum_at_least_core: random and directed sequences,
// an in-bench shortest-window predictor, and beat-by-beat result checks.
// Depends on mlws_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
   import mlws_pkg::*;

   localparam int WIN_DEPTH   = 1024;
   localparam int ITEM_BUDGET = 1890;

   typedef enum int {VAL_FULL, VAL_SMALL, VAL_EDGE} value_mix_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en = 1'b0;
   logic [TARGET_W-1:0] csr_wr_data = '0;

   // predictor state
   logic [TARGET_W-1:0]      target_now = TARGET_RESET;
   logic [VALUE_FIELD_W-1:0] kept_values [0:WIN_DEPTH-1];
   logic [63:0]              window_total = '0;
   int unsigned              left_idx = 0;
   int unsigned              seq_count = 0;
   int unsigned              shortest = 0;

   req_type     value_queue [$];
   rsp_type     expected_best [$];
   rsp_type     want;
   int          mismatches = 0;
   int          total_items = 0;
   bit          beat_taken = 1'b0;
   int          send_gap = 0;
   int          recv_stall = 0;
   int          hold_cycles = 0;
   bit          hold_request = 1'b0;
   bit          send_idle_on = 1'b1;
   bit          recv_idle_on = 1'b1;

   min_length_window_sum_at_least_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_window();
      window_total = '0;
      left_idx     = 0;
      seq_count    = 0;
      shortest     = 0;
   endfunction

   function automatic rsp_type shortest_window_step(req_type item);
      rsp_type r;
      logic    ovf;
      ovf = 1'b0;
      if (seq_count >= WIN_DEPTH) begin
         ovf = 1'b1;
      end else begin
         kept_values[seq_count] = item.value;
         window_total += item.value;
         seq_count++;
         if (window_total >= target_now) begin
            // shrink from the left while the sum still qualifies
            while (left_idx + 1 < seq_count &&
                   window_total - kept_values[left_idx] >= target_now) begin
               window_total -= kept_values[left_idx];
               left_idx++;
            end
            if (shortest == 0 || seq_count - left_idx < shortest)
               shortest = seq_count - left_idx;
         end
      end
      r.best_length = shortest[BEST_LEN_W-1:0];
      r.found       = (shortest != 0);
      r.is_final    = item.is_last;
      r.overflow    = ovf;
      if (item.is_last)
         clear_window();
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [VALUE_FIELD_W-1:0] pick_value(value_mix_type mix);
      int r;
      r = $urandom_range(0, 9);
      case (mix)
         VAL_SMALL: return VALUE_FIELD_W'($urandom_range(0, 15));
         VAL_EDGE: begin
            if (r < 2)
               return '0;
            if (r < 5)
               return '1;
            return VALUE_FIELD_W'($urandom);
         end
         default: return VALUE_FIELD_W'($urandom);
      endcase
   endfunction

   task automatic add_item(input logic [VALUE_FIELD_W-1:0] v, input logic last);
      req_type b;
      b.value   = v;
      b.is_last = last;
      value_queue.push_back(b);
      total_items++;
   endtask

   task automatic add_sequence(input int len, input value_mix_type mix);
      for (int i = 0; i < len; i++)
         add_item(pick_value(mix), i == len - 1);
   endtask

   // wait until every queued beat is sent and its result has come back
   task automatic settle();
      int waited;
      waited = 0;
      @(posedge clock);
      while (value_queue.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_best.size() != 0 && waited < 2000) begin
         waited++;
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_target(input logic [TARGET_W-1:0] t);
      settle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= t;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || beat_taken) begin
         beat_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (value_queue.size() != 0) begin
            req_data  <= value_queue.pop_front();
            req_valid <= 1'b1;
            send_gap = send_idle_on ? pick_gap() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with an occasional long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_cycles = 300;
         rsp_ready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_ready <= 1'b0;
      end else begin
         recv_stall = recv_idle_on ? pick_gap() : 0;
         rsp_ready <= 1'b1;
      end
   end

   // predictor and checker
   always @(posedge clock) begin
      if (reset) begin
         target_now = TARGET_RESET;
         clear_window();
      end else begin
         if (csr_wr_en)
            target_now = csr_wr_data;
         if (req_valid && req_ready) begin
            expected_best.push_back(shortest_window_step(req_data));
            beat_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_best.size() == 0) begin
               $error("result beat with nothing expected: %p", rsp_data);
               mismatches++;
            end else begin
               want = expected_best.pop_front();
               if (rsp_data.best_length !== want.best_length) begin
                  $error("best_length: expected %0d, got %0d",
                         want.best_length, rsp_data.best_length);
                  mismatches++;
               end
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_data.found);
                  mismatches++;
               end
               if (rsp_data.is_final !== want.is_final) begin
                  $error("is_final: expected %0d, got %0d", want.is_final, rsp_data.is_final);
                  mismatches++;
               end
               if (rsp_data.overflow !== want.overflow) begin
                  $error("overflow: expected %0d, got %0d", want.overflow, rsp_data.overflow);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      logic [TARGET_W-1:0] t;
      value_mix_type       mix;
      int                  phase;
      int                  nseq;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset target of 1: zero alone never qualifies, any nonzero does
      add_item(16'd0, 1'b1);
      add_item(16'd0, 1'b0);
      add_item(16'd0, 1'b0);
      add_item(16'd5, 1'b1);
      // unreachable target
      write_target('1);
      add_item(16'hFFFF, 1'b0);
      add_item(16'hFFFF, 1'b1);
      // zero target: every element qualifies alone
      write_target('0);
      add_item(16'd0, 1'b0);
      add_item(16'd7, 1'b0);
      add_item(16'd0, 1'b1);
      // first reached by a maximal value, a zero and a one, then shrinks past the zero
      write_target(32'd65536);
      add_item(16'hFFFF, 1'b0);
      add_item(16'd0, 1'b0);
      add_item(16'd1, 1'b0);
      add_item(16'hFFFF, 1'b1);
      write_target(32'd3);
      add_item(16'd1, 1'b0);
      add_item(16'd1, 1'b0);
      add_item(16'd1, 1'b0);
      add_item(16'd3, 1'b1);
      add_item(16'hAAAA, 1'b0);
      add_item(16'h5555, 1'b1);

      phase = 0;
      while (total_items < ITEM_BUDGET) begin
         case ($urandom_range(0, 5))
            0: begin
               t = TARGET_W'($urandom_range(1, 40));
               mix = VAL_SMALL;
            end
            1, 2: begin
               t = TARGET_W'($urandom_range(1, 300000));
               mix = VAL_FULL;
            end
            3: begin
               t = TARGET_W'($urandom_range(60000, 140000));
               mix = VAL_EDGE;
            end
            4: begin
               t = TARGET_W'($urandom_range(1, 3));
               mix = VAL_EDGE;
            end
            default: begin
               t = TARGET_W'($urandom);
               mix = VAL_FULL;
            end
         endcase
         if (phase == 3)
            t = TARGET_W'($urandom_range(500000, 3000000));
         write_target(t);
         send_idle_on = ($urandom_range(0, 3) != 0);
         recv_idle_on = ($urandom_range(0, 3) != 0);
         if (phase == 3) begin
            // runs past the buffer depth; trailing beats come back flagged
            add_sequence(WIN_DEPTH + 6, VAL_FULL);
         end else begin
            nseq = $urandom_range(3, 6);
            repeat (nseq) begin
               if ($urandom_range(0, 99) < 85)
                  add_sequence($urandom_range(1, 16), mix);
               else
                  add_sequence($urandom_range(17, 60), mix);
            end
         end
         if (phase == 1)
            hold_request = 1'b1;
         phase++;
      end

      settle();
      repeat (20) @(posedge clock);
      if (expected_best.size() != 0) begin
         $error("%0d results never arrived", expected_best.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
